// ===== sv/rtc_pkg.sv =====
`timescale 1ns / 1ps
package rtc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAX_TRIANGLES = 65536;
	localparam int POS_W = $clog2(MAX_TRIANGLES);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd6;
	localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SAT_MIN = -32'sh7FFFFFFF - 32'sd1;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
	localparam int DIV_STEPS = 64;

	typedef struct packed {
		logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
		logic last_triangle;
	} tri_t;

	typedef struct packed {
		logic hit_found;
		logic signed [31:0] hit_distance, hit_x, hit_y, hit_z;
		logic [15:0] hit_index;
	} hit_t;

	typedef enum logic [3:0] {
		OP_LOAD = 4'd0, OP_EDGE = 4'd1, OP_MUL = 4'd2, OP_CHECK = 4'd3,
		OP_DIVSTART = 4'd4, OP_DIVSTEP = 4'd5, OP_UPDATE = 4'd6, OP_POINT = 4'd7,
		OP_FINISH = 4'd8, OP_NONE = 4'd9
	} op_t;

	typedef struct packed {
		op_t op;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic div_done;
		logic last;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'(SAT_MAX)) return SAT_MAX;
		if (x < 66'(SAT_MIN)) return SAT_MIN;
		return x[31:0];
	endfunction
endpackage

// ===== sv/rtc_if.sv =====
`timescale 1ns / 1ps
interface rtc_tri_if import rtc_pkg::*; ();
	logic valid;
	logic ready;
	tri_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rtc_hit_if import rtc_pkg::*; ();
	logic valid;
	logic ready;
	hit_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/rtc_datapath.sv =====
`timescale 1ns / 1ps
module rtc_datapath import rtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input tri_t tri_in,
	input logic signed [31:0] origin_x, origin_y, origin_z,
	input logic signed [17:0] dir_x, dir_y, dir_z,
	input logic [15:0] epsilon,
	output hit_t result
);
	logic signed [31:0] a_q [3], b_q [3], c_q [3];
	logic signed [31:0] e1_q [3], e2_q [3], s_q [3], p_q [3], q_q [3];
	logic signed [31:0] dir [3], org [3];
	logic signed [65:0] acc_q, det_q, nu_q, nv_q, nt_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] ma, mb;
	logic last_q;
	logic [63:0] rem_q, num_q, den_q;
	logic [31:0] quo_q;
	logic [6:0] dcnt_q;
	logic signed [31:0] t_q;
	logic signed [31:0] best_d_q, best_p_q [3];
	logic [POS_W-1:0] pos_q, best_pos_q;
	logic any_q, upd_q;
	logic signed [65:0] pshift;
	logic [64:0] rtry;

	assign dir[0] = 32'(dir_x);
	assign dir[1] = 32'(dir_y);
	assign dir[2] = 32'(dir_z);
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;

	// multiply schedule: step selects operands; product registered, accumulated next step
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.step)
			5'd0: begin ma = dir[1]; mb = e2_q[2]; end
			5'd1: begin ma = dir[2]; mb = e2_q[1]; end
			5'd2: begin ma = dir[2]; mb = e2_q[0]; end
			5'd3: begin ma = dir[0]; mb = e2_q[2]; end
			5'd4: begin ma = dir[0]; mb = e2_q[1]; end
			5'd5: begin ma = dir[1]; mb = e2_q[0]; end
			5'd6: begin ma = e1_q[0]; mb = p_q[0]; end
			5'd7: begin ma = e1_q[1]; mb = p_q[1]; end
			5'd8: begin ma = e1_q[2]; mb = p_q[2]; end
			5'd9: begin ma = s_q[0]; mb = p_q[0]; end
			5'd10: begin ma = s_q[1]; mb = p_q[1]; end
			5'd11: begin ma = s_q[2]; mb = p_q[2]; end
			5'd12: begin ma = s_q[1]; mb = e1_q[2]; end
			5'd13: begin ma = s_q[2]; mb = e1_q[1]; end
			5'd14: begin ma = s_q[2]; mb = e1_q[0]; end
			5'd15: begin ma = s_q[0]; mb = e1_q[2]; end
			5'd16: begin ma = s_q[0]; mb = e1_q[1]; end
			5'd17: begin ma = s_q[1]; mb = e1_q[0]; end
			5'd18: begin ma = dir[0]; mb = q_q[0]; end
			5'd19: begin ma = dir[1]; mb = q_q[1]; end
			5'd20: begin ma = dir[2]; mb = q_q[2]; end
			5'd21: begin ma = e2_q[0]; mb = q_q[0]; end
			5'd22: begin ma = e2_q[1]; mb = q_q[1]; end
			5'd23: begin ma = e2_q[2]; mb = q_q[2]; end
			5'd24: begin ma = t_q; mb = dir[0]; end
			5'd25: begin ma = t_q; mb = dir[1]; end
			5'd26: begin ma = t_q; mb = dir[2]; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign pshift = 66'(prod_s1 >>> FRAC_BITS);
	assign rtry = {rem_q, num_q[63]} ;

	logic signed [65:0] adet, anu, anv, ant;
	always_comb begin
		adet = det_q[65] ? -det_q : det_q;
		anu = det_q[65] ? -nu_q : nu_q;
		anv = det_q[65] ? -nv_q : nv_q;
		ant = det_q[65] ? -nt_q : nt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_d_q <= SAT_MAX;
			any_q <= 1'b0;
			pos_q <= '0;
			best_pos_q <= '0;
			upd_q <= 1'b0;
			dcnt_q <= '0;
			sts <= '0;
			for (int i = 0; i < 3; i++) best_p_q[i] <= '0;
		end else begin
			sts.div_done <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					a_q[0] <= tri_in.a_x; a_q[1] <= tri_in.a_y; a_q[2] <= tri_in.a_z;
					b_q[0] <= tri_in.b_x; b_q[1] <= tri_in.b_y; b_q[2] <= tri_in.b_z;
					c_q[0] <= tri_in.c_x; c_q[1] <= tri_in.c_y; c_q[2] <= tri_in.c_z;
					last_q <= tri_in.last_triangle;
					sts.last <= tri_in.last_triangle;
					sts.reject <= 1'b0;
				end
				OP_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= sat32(66'(b_q[i]) - 66'(a_q[i]));
						e2_q[i] <= sat32(66'(c_q[i]) - 66'(a_q[i]));
						s_q[i] <= sat32(66'(org[i]) - 66'(a_q[i]));
					end
				end
				OP_MUL: begin
					prod_s1 <= 64'(ma) * 64'(mb);
					// accumulate previous product (step-1)
					unique case (cmd.step)
						5'd1, 5'd3, 5'd5, 5'd13, 5'd15, 5'd17: acc_q <= pshift;
						5'd2: p_q[0] <= sat32(acc_q - pshift);
						5'd4: p_q[1] <= sat32(acc_q - pshift);
						5'd6: p_q[2] <= sat32(acc_q - pshift);
						5'd7, 5'd10, 5'd19, 5'd22: acc_q <= pshift;
						5'd8, 5'd11, 5'd20, 5'd23: acc_q <= acc_q + pshift;
						5'd9: begin det_q <= acc_q + pshift; acc_q <= '0; end
						5'd12: nu_q <= acc_q + pshift;
						5'd14: q_q[0] <= sat32(acc_q - pshift);
						5'd16: q_q[1] <= sat32(acc_q - pshift);
						5'd18: q_q[2] <= sat32(acc_q - pshift);
						5'd21: nv_q <= acc_q + pshift;
						5'd24: nt_q <= acc_q + pshift;
						5'd25: best_p_q[0] <= upd_q ? sat32(66'(org[0]) + pshift) : best_p_q[0];
						5'd26: best_p_q[1] <= upd_q ? sat32(66'(org[1]) + pshift) : best_p_q[1];
						5'd27: best_p_q[2] <= upd_q ? sat32(66'(org[2]) + pshift) : best_p_q[2];
						default: ;
					endcase
				end
				OP_CHECK: begin
					if (cmd.step == 5'd0)
						sts.reject <= (det_q == 0) || (adet < 66'($signed({1'b0, epsilon})));
					else
						sts.reject <= (anu < 0) || (anu > adet) || (anv < 0) ||
							(anu + anv > adet) || (ant <= 0);
				end
				OP_DIVSTART: begin
					num_q <= ant[63:0];
					den_q <= adet[63:0];
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 7'(DIV_STEPS + FRAC_BITS);
				end
				OP_DIVSTEP: begin
					// restoring divide of (nt << FRAC_BITS) by det, saturating quotient
					if (rtry >= {1'b0, den_q}) begin
						rem_q <= 64'(rtry - {1'b0, den_q});
						quo_q <= quo_q[31] ? 32'hFFFFFFFF : {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rtry[63:0];
						quo_q <= quo_q[31] ? 32'hFFFFFFFF : {quo_q[30:0], 1'b0};
					end
					num_q <= {num_q[62:0], 1'b0};
					dcnt_q <= dcnt_q - 7'd1;
					if (dcnt_q == 7'd2) sts.div_done <= 1'b1;
				end
				OP_UPDATE: begin
					logic signed [31:0] tv;
					tv = quo_q[31] ? SAT_MAX : $signed(quo_q);
					t_q <= tv;
					upd_q <= (tv > $signed({16'd0, epsilon})) && (!any_q || tv < best_d_q);
					if ((tv > $signed({16'd0, epsilon})) && (!any_q || tv < best_d_q)) begin
						any_q <= 1'b1;
						best_d_q <= tv;
						best_pos_q <= pos_q;
					end
				end
				OP_FINISH: begin
					upd_q <= 1'b0;
					pos_q <= (32'(pos_q) + 32'd1 >= 32'(MAX_TRIANGLES)) ? '0 : pos_q + 1'b1;
					if (last_q) begin
						result.hit_found <= any_q;
						result.hit_distance <= any_q ? best_d_q : -ONE_Q;
						result.hit_x <= any_q ? best_p_q[0] : '0;
						result.hit_y <= any_q ? best_p_q[1] : '0;
						result.hit_z <= any_q ? best_p_q[2] : '0;
						result.hit_index <= any_q ? 16'(best_pos_q) : '0;
						any_q <= 1'b0;
						best_d_q <= SAT_MAX;
						best_pos_q <= '0;
						pos_q <= '0;
						for (int i = 0; i < 3; i++) best_p_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== sv/rtc_ctrl.sv =====
`timescale 1ns / 1ps
module rtc_ctrl import rtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_EDGE = 7'b0000010, S_MUL = 7'b0000100,
		S_DIV = 7'b0001000, S_UPD = 7'b0010000, S_FIN = 7'b0100000,
		S_CHK = 7'b1000000
	} state_t;
	state_t state_q;
	logic [4:0] step_q;
	logic div_start_q;
	logic pt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE: cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
			S_EDGE: cmd.op = OP_EDGE;
			S_MUL: cmd.op = OP_MUL;
			S_CHK: cmd.op = OP_CHECK;
			S_DIV: cmd.op = div_start_q ? OP_DIVSTART : OP_DIVSTEP;
			S_UPD: cmd.op = OP_UPDATE;
			S_FIN: cmd.op = (sts.last && out_valid) ? OP_NONE : OP_FINISH;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			out_valid <= 1'b0;
			div_start_q <= 1'b0;
			pt_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_EDGE;
				S_EDGE: begin step_q <= '0; pt_q <= 1'b0; state_q <= S_MUL; end
				S_MUL: begin
					if (step_q == 5'd9) begin
						step_q <= 5'd0; state_q <= S_CHK;
					end else if (step_q == 5'd10 && sts.reject) begin
						state_q <= S_FIN;
					end else if (step_q == 5'd24 && !pt_q) begin
						step_q <= 5'd1; state_q <= S_CHK;
					end else begin
						step_q <= step_q + 5'd1;
						if (step_q == 5'd27) state_q <= S_FIN;
					end
				end
				S_CHK: begin
					if (step_q == 5'd0) begin
						step_q <= 5'd10; state_q <= S_MUL;
					end else begin
						state_q <= S_DIV; div_start_q <= 1'b1;
					end
				end
				S_DIV: begin
					div_start_q <= 1'b0;
					if (div_start_q && sts.reject) state_q <= S_FIN;
					else if (!div_start_q && sts.div_done) state_q <= S_UPD;
				end
				S_UPD: begin step_q <= 5'd24; pt_q <= 1'b1; state_q <= S_MUL; end
				S_FIN: begin
					if (!sts.last) state_q <= S_IDLE;
					else if (!out_valid) begin out_valid <= 1'b1; state_q <= S_IDLE; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/ray_triangle_closest_hit.sv =====
`timescale 1ns / 1ps
// Flow: a triangle that reaches the divide takes 28 multiply steps on one shared
// 32x32 multiplier, two checks and an 80-step restoring divider for t; a determinant
// reject ends after the first check, a u/v/t reject after the second.
// One request at a time: input is ready only when idle; a result waits in its output
// register and only the next last triangle stalls in finish until it is taken.
// Reset: asynchronous active low; origin 0, dir (0,0,1.0), epsilon 1, run state cleared.
module ray_triangle_closest_hit import rtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	rtc_tri_if.sink tri_ch,
	rtc_hit_if.source hit_ch,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [17:0] dir_x_q, dir_y_q, dir_z_q;
	logic [15:0] epsilon_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0; origin_y_q <= '0; origin_z_q <= '0;
			dir_x_q <= '0; dir_y_q <= '0; dir_z_q <= 18'(ONE_Q);
			epsilon_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				REG_DIR_X: dir_x_q <= cfg_data[17:0];
				REG_DIR_Y: dir_y_q <= cfg_data[17:0];
				REG_DIR_Z: dir_z_q <= cfg_data[17:0];
				REG_EPSILON: epsilon_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rtc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(tri_ch.valid), .in_ready(tri_ch.ready),
		.out_valid(hit_ch.valid), .out_ready(hit_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	rtc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .tri_in(tri_ch.data),
		.origin_x(origin_x_q), .origin_y(origin_y_q), .origin_z(origin_z_q),
		.dir_x(dir_x_q), .dir_y(dir_y_q), .dir_z(dir_z_q),
		.epsilon(epsilon_q), .result(hit_ch.data)
	);
endmodule
